### hw/rtl/slrg_pkg.sv
// package with constants and command/status types of the shuffled lcg generator
`default_nettype none

package slrg_pkg;

  // generator constants
  localparam logic [30:0] Modulus    = 31'h7FFF_FFFF;
  localparam logic [14:0] Multiplier = 15'd16807;
  localparam int unsigned Warmup     = 8;
  localparam logic [31:0] SeedReset  = 32'hFF43_9EB2; // minus 12345678

  // product width: 15-bit multiplier times 32-bit operand
  localparam int unsigned ProdW = 47;

  // commands from controller to datapath
  typedef struct packed {
    logic load_seed;
    logic start_refill;
    logic start_draw;
    logic mul;
    logic fold_refill;
    logic fold_draw;
    logic div_step;
    logic rd;
    logic wr_out;
  } slrg_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_refill;
    logic cnt_zero;
    logic out_busy;
  } slrg_sts_t;

endpackage

`default_nettype wire

### hw/rtl/slrg_ctrl.sv
// controller state machine of the shuffled lcg generator
`default_nettype none

module slrg_ctrl
  import slrg_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        op_i,
  input  slrg_sts_t  sts_i,
  output slrg_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StRfMul  = 3'd1;
  localparam logic [2:0] StRfFold = 3'd2;
  localparam logic [2:0] StDrMul  = 3'd3;
  localparam logic [2:0] StDrFold = 3'd4;
  localparam logic [2:0] StDiv    = 3'd5;
  localparam logic [2:0] StRd     = 3'd6;
  localparam logic [2:0] StWr     = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (op_i) begin
            cmd_o.load_seed = 1'b1;
          end else if (sts_i.need_refill) begin
            cmd_o.start_refill = 1'b1;
            state_d = StRfMul;
          end else begin
            cmd_o.start_draw = 1'b1;
            state_d = StDrMul;
          end
        end
      end
      StRfMul: begin
        cmd_o.mul = 1'b1;
        state_d = StRfFold;
      end
      StRfFold: begin
        cmd_o.fold_refill = 1'b1;
        state_d = sts_i.cnt_zero ? StDrMul : StRfMul;
      end
      StDrMul: begin
        cmd_o.mul = 1'b1;
        state_d = StDrFold;
      end
      StDrFold: begin
        cmd_o.fold_draw = 1'b1;
        state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        state_d = StRd;
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d = StWr;
      end
      StWr: begin
        if (!sts_i.out_busy) begin
          cmd_o.wr_out = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/slrg_datapath.sv
// datapath of the shuffled lcg generator: seed, multiplier, fold, slot index, table
`default_nettype none

module slrg_datapath
  import slrg_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  slrg_cmd_t         cmd_i,
  input  wire signed [31:0] seed_value_i,
  input  wire               out_stall_i,
  output slrg_sts_t         sts_o,
  output logic              out_valid_o,
  output logic [30:0]       value_o
);

  localparam int unsigned SW = $clog2(TABLE_SIZE);
  localparam int unsigned QW = SW + 1;
  localparam int unsigned CW = $clog2(TABLE_SIZE + Warmup);
  localparam logic [31:0] SlotDiv =
    32'(64'd1 + (64'd2147483646 / 64'(TABLE_SIZE)));
  // reciprocal of the slot divisor, exact for every 31-bit dividend
  localparam int unsigned SlotDivLog = $clog2(SlotDiv);
  localparam int unsigned SlotShift  = 31 + SlotDivLog;
  localparam logic [31:0] SlotRecip  =
    32'(((64'd1 << SlotShift) + 64'(SlotDiv) - 64'd1) / 64'(SlotDiv));

  logic signed [31:0] seed_q;
  logic [30:0]        last_q;
  logic [31:0]        x_q;
  logic [ProdW-1:0]   prod_q;
  logic [CW-1:0]      cnt_q;
  logic [QW-1:0]      quo_q;
  logic [30:0]        rd_q;
  logic [30:0]        out_q;
  logic               out_valid_q;
  logic [30:0]        table_mem [TABLE_SIZE];

  logic [31:0]        fold_sum;
  logic [30:0]        fold_val;
  logic [62:0]        slot_prod;
  logic [SW-1:0]      slot;
  logic               mem_we;
  logic [SW-1:0]      mem_waddr;

  // mersenne fold of the product modulo 2^31-1
  assign fold_sum = 32'(prod_q[ProdW-1:31]) + {1'b0, prod_q[30:0]};
  assign fold_val = (fold_sum >= {1'b0, Modulus}) ? 31'(fold_sum - {1'b0, Modulus})
                                                  : fold_sum[30:0];

  // slot quotient of the last output by reciprocal multiplication
  assign slot_prod = 63'(last_q) * 63'(SlotRecip);

  // slot index with clamp to the last entry
  assign slot = (quo_q >= QW'(TABLE_SIZE)) ? SW'(TABLE_SIZE - 1) : quo_q[SW-1:0];

  // table write port: refill fills, draw swaps in the new seed
  assign mem_we    = (cmd_i.fold_refill && (cnt_q < CW'(TABLE_SIZE))) || cmd_i.wr_out;
  assign mem_waddr = cmd_i.wr_out ? slot : cnt_q[SW-1:0];

  // status
  assign sts_o.need_refill = seed_q[31] || (seed_q == 32'sd0) || (last_q == 31'd0);
  assign sts_o.cnt_zero    = (cnt_q == '0);
  assign sts_o.out_busy    = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q;

  // generator state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= SeedReset;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_seed) begin
        seed_q <= seed_value_i;
      end else if (cmd_i.fold_draw || (cmd_i.fold_refill && (cnt_q == '0))) begin
        seed_q <= signed'({1'b0, fold_val});
      end
      if (cmd_i.fold_refill && (cnt_q == '0)) begin
        last_q <= fold_val;
      end else if (cmd_i.wr_out) begin
        last_q <= rd_q;
      end
      if (cmd_i.wr_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_refill) begin
      x_q   <= seed_q[31] ? (32'd0 - seed_q) : 32'd1;
      cnt_q <= CW'(TABLE_SIZE + Warmup - 1);
    end else if (cmd_i.start_draw) begin
      x_q <= seed_q;
    end else if (cmd_i.fold_refill || cmd_i.fold_draw) begin
      x_q <= {1'b0, fold_val};
    end
    if (cmd_i.fold_refill && (cnt_q != '0)) begin
      cnt_q <= cnt_q - CW'(1);
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(x_q) * ProdW'(Multiplier);
    end
    if (cmd_i.div_step) begin
      quo_q <= QW'(slot_prod >> SlotShift);
    end
    if (cmd_i.wr_out) begin
      out_q <= rd_q;
    end
  end

  // shuffle table memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= cmd_i.wr_out ? x_q[30:0] : fold_val;
    end
    if (cmd_i.rd) begin
      rd_q <= table_mem[slot];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/shuffled_lcg_random_generator_unit.sv
// top level of the shuffled minimal-standard random generator
//
// input channel: in_valid_i / in_stall_o with op_i and seed_value_i. op 1 loads
// the seed and gives no result; op 0 draws one number from the shuffle table.
// output channel: out_valid_o / out_stall_i with value_o, one item per draw.
// an item is accepted only while the controller is idle. a seed load leaves the
// controller idle. a draw runs from acceptance to the result through multiply,
// fold, slot index by reciprocal multiply, table read and table swap; the next
// item can be accepted in the cycle after the swap, so a draw stalls the input.
// a draw that needs a refill first runs TABLE_SIZE+8 generator steps, each a
// multiply and a fold on the shared multiplier and fold.
// the result sits in an output register; the next item is accepted while it
// waits, and a later draw holds in its last step until the receiver takes it.
// reset sets the seed to -12345678 and the last output to zero, so the first
// draw always refills the table; table contents are not cleared.
`default_nettype none

module shuffled_lcg_random_generator_unit
  import slrg_pkg::*;
#(
  parameter int unsigned TABLE_SIZE = 32
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               op_i,
  input  wire signed [31:0] seed_value_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [30:0]       value_o
);

  slrg_cmd_t cmd;
  slrg_sts_t sts;

  // sequencing
  slrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and table
  slrg_datapath #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .seed_value_i (seed_value_i),
    .out_stall_i  (out_stall_i),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o)
  );

endmodule

`default_nettype wire
